// ===== rtl/ils_pkg.sv =====
// shared types, widths and codes for the indexed list store
// no dependencies; used by every rtl file of the block
`default_nettype none

package ils_pkg;

    // sizing
    localparam int CAPACITY    = 32;
    localparam int STORE_DEPTH = 32;
    localparam int USABLE_CAP  = (CAPACITY < STORE_DEPTH) ? CAPACITY : STORE_DEPTH;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    // field widths
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 6;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request codes on the input func field
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // decoded operation carried through the queue
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_DUMP   = 2'd2
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    // back-end sequencer states
    typedef enum logic {
        B_IDLE = 1'b0,
        B_DUMP = 1'b1
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/ils_front.sv =====
// front end: takes input words, decodes the request and pushes a command
// depends on ils_pkg
`default_nettype none

module ils_front (
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [ils_pkg::FUNC_W-1:0]   s_func,
    input  wire logic [ils_pkg::POS_W-1:0]    s_position,
    input  wire logic signed [ils_pkg::VAL_W-1:0] s_value,
    input  wire logic                         q_full,
    output logic                              q_push,
    output ils_pkg::cmd_t                     q_cmd
);

    logic known;

    always_comb begin
        known       = 1'b1;
        q_cmd.op    = ils_pkg::OP_INSERT;
        case (s_func)
            ils_pkg::FUNC_INSERT: begin
                q_cmd.op = ils_pkg::OP_INSERT;
            end
            ils_pkg::FUNC_REMOVE: begin
                q_cmd.op = ils_pkg::OP_REMOVE;
            end
            ils_pkg::FUNC_DUMP: begin
                q_cmd.op = ils_pkg::OP_DUMP;
            end
            default: begin
                // unused code is swallowed without a result
                known = 1'b0;
            end
        endcase
        q_cmd.position = s_position;
        q_cmd.value    = s_value;
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && known;

endmodule

`default_nettype wire

// ===== rtl/ils_queue.sv =====
// short command queue between front and back ends
// depends on ils_pkg
`default_nettype none

module ils_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire ils_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               q_valid,
    output ils_pkg::cmd_t      head_cmd
);

    ils_pkg::cmd_t                 slot_reg [ils_pkg::QUEUE_DEPTH];
    logic [ils_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [ils_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [ils_pkg::QCNT_W-1:0]    fill_reg;
    logic [ils_pkg::QCNT_W-1:0]    fill_next;
    logic                          do_push;
    logic                          do_pop;

    assign full     = (fill_reg == ils_pkg::QCNT_W'(ils_pkg::QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ils_back.sv =====
// back end: shift-register store, request checks, dump sequencer, result register
// depends on ils_pkg
`default_nettype none

module ils_back (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             q_valid,
    input  wire ils_pkg::cmd_t                    q_cmd,
    output logic                                  q_pop,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [ils_pkg::STATUS_W-1:0]          m_status,
    output logic [ils_pkg::CNT_W-1:0]             m_count,
    output logic                                  m_has_value,
    output logic signed [ils_pkg::VAL_W-1:0]      m_item_value,
    output logic                                  m_last
);

    localparam int DEPTH = ils_pkg::STORE_DEPTH;

    logic signed [ils_pkg::VAL_W-1:0] entries_reg [DEPTH];
    logic [ils_pkg::CNT_W-1:0]        occ_reg;
    logic [ils_pkg::CNT_W-1:0]        occ_next;
    logic [ils_pkg::IDX_W-1:0]        idx_reg;
    logic [ils_pkg::IDX_W-1:0]        idx_next;
    ils_pkg::back_state_t             state_reg;
    ils_pkg::back_state_t             state_next;

    logic                             m_valid_reg;
    ils_pkg::status_t                 m_status_reg;
    logic [ils_pkg::CNT_W-1:0]        m_count_reg;
    logic                             m_has_value_reg;
    logic signed [ils_pkg::VAL_W-1:0] m_item_value_reg;
    logic                             m_last_reg;

    logic                             out_free;
    logic                             load;
    logic                             ins_en;
    logic                             rem_en;
    ils_pkg::status_t                 res_status;
    logic                             res_has;
    logic signed [ils_pkg::VAL_W-1:0] res_value;
    logic                             res_last;
    logic [ils_pkg::IDX_W-1:0]        rd_idx;
    logic signed [ils_pkg::VAL_W-1:0] rd_data;
    logic                             dump_last;
    logic                             occ_is_one;

    assign out_free   = !m_valid_reg || m_ready;
    assign rd_idx     = (state_reg == ils_pkg::B_DUMP) ? idx_reg : '0;
    assign rd_data    = entries_reg[rd_idx];
    assign dump_last  = (({1'b0, idx_reg} + 1'b1) == occ_reg);
    assign occ_is_one = (occ_reg == ils_pkg::CNT_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ils_pkg::B_IDLE: begin
                if (q_valid && out_free && q_cmd.op == ils_pkg::OP_DUMP &&
                    occ_reg != '0 && !occ_is_one) begin
                    state_next = ils_pkg::B_DUMP;
                end
            end
            ils_pkg::B_DUMP: begin
                if (out_free && dump_last) begin
                    state_next = ils_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = ils_pkg::B_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        q_pop      = 1'b0;
        load       = 1'b0;
        ins_en     = 1'b0;
        rem_en     = 1'b0;
        res_status = ils_pkg::ST_OK;
        res_has    = 1'b0;
        res_value  = '0;
        res_last   = 1'b1;
        occ_next   = occ_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ils_pkg::B_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    load  = 1'b1;
                    case (q_cmd.op)
                        ils_pkg::OP_INSERT: begin
                            if (q_cmd.position > occ_reg) begin
                                res_status = ils_pkg::ST_RANGE;
                            end else if (occ_reg >= ils_pkg::CNT_W'(ils_pkg::USABLE_CAP)) begin
                                res_status = ils_pkg::ST_FULL;
                            end else begin
                                ins_en   = 1'b1;
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        ils_pkg::OP_REMOVE: begin
                            if (occ_reg == '0) begin
                                res_status = ils_pkg::ST_EMPTY;
                            end else if (q_cmd.position >= occ_reg) begin
                                res_status = ils_pkg::ST_RANGE;
                            end else begin
                                rem_en   = 1'b1;
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        ils_pkg::OP_DUMP: begin
                            if (occ_reg == '0) begin
                                res_status = ils_pkg::ST_EMPTY;
                            end else begin
                                // head word goes out now, the rest from the dump state
                                res_has   = 1'b1;
                                res_value = rd_data;
                                res_last  = occ_is_one;
                                idx_next  = ils_pkg::IDX_W'(1);
                            end
                        end
                        default: begin
                            res_status = ils_pkg::ST_OK;
                        end
                    endcase
                end
            end
            ils_pkg::B_DUMP: begin
                if (out_free) begin
                    load      = 1'b1;
                    res_has   = 1'b1;
                    res_value = rd_data;
                    res_last  = dump_last;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ils_pkg::B_IDLE;
            occ_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            idx_reg   <= idx_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_status_reg     <= res_status;
            m_count_reg      <= occ_next;
            m_has_value_reg  <= res_has;
            m_item_value_reg <= res_value;
            m_last_reg       <= res_last;
        end
    end

    // cells past the insert point, or from the remove point up, shift in parallel
    always_ff @(posedge aclk) begin
        if (ins_en) begin
            if (q_cmd.position == '0) begin
                entries_reg[0] <= q_cmd.value;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (ils_pkg::POS_W'(i) == q_cmd.position) begin
                    entries_reg[i] <= q_cmd.value;
                end else if (ils_pkg::POS_W'(i) > q_cmd.position) begin
                    entries_reg[i] <= entries_reg[i-1];
                end
            end
        end else if (rem_en) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (ils_pkg::POS_W'(i) >= q_cmd.position) begin
                    entries_reg[i] <= entries_reg[i+1];
                end
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_count      = m_count_reg;
    assign m_has_value  = m_has_value_reg;
    assign m_item_value = m_item_value_reg;
    assign m_last       = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_store_top.sv =====
// indexed list store: insert/remove at position, ordered dump; one result word per insert or remove
// a request is held in the command queue, then its result word is registered once the output is free
// one insert or remove per cycle unless stalled; a dump gives one word per stored value (up to 32)
// the dump sequencer in the back end holds off later requests until the dump ends
// reset (aresetn, sync, active low) empties the list, the command queue and the result register
// stored values are not cleared; only entries below the count are ever shown
`default_nettype none

module indexed_list_store_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // request words
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [ils_pkg::FUNC_W-1:0]        s_func,
    input  wire logic [ils_pkg::POS_W-1:0]         s_position,
    input  wire logic signed [ils_pkg::VAL_W-1:0]  s_value,
    // result words
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [ils_pkg::STATUS_W-1:0]           m_status,
    output logic [ils_pkg::CNT_W-1:0]              m_count,
    output logic                                   m_has_value,
    output logic signed [ils_pkg::VAL_W-1:0]       m_item_value,
    output logic                                   m_last
);

    // decoded command handed from front to queue
    ils_pkg::cmd_t push_cmd;
    logic          push;
    logic          q_full;

    // queue head seen by the back end
    ils_pkg::cmd_t head_cmd;
    logic          q_valid;
    logic          pop;

    // front: decode the func code, drop the unused one, push the rest
    ils_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_position (s_position),
        .s_value    (s_value),
        .q_full     (q_full),
        .q_push     (push),
        .q_cmd      (push_cmd)
    );

    // two-entry queue so the front keeps taking words while a dump streams
    ils_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head_cmd (head_cmd)
    );

    // back: range and capacity checks, parallel shift of the store, result register
    ils_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_cmd        (head_cmd),
        .q_pop        (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_has_value  (m_has_value),
        .m_item_value (m_item_value),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for indexed_list_store_top: insert, remove and ordered dump
// depends on rtl/ils_pkg.sv and the block's rtl files under rtl/
// a shadow copy of the list predicts every result word, compared field by field
module testbench;

    // the one func code the block ignores
    localparam logic [ils_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic signed [ils_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ils_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    // slowest correct run is far below this: ~240 requests, each up to 32 result
    // words, every word waiting out receiver stalls
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        ils_pkg::status_t                 status;
        logic [ils_pkg::CNT_W-1:0]        count;
        logic                             has_value;
        logic signed [ils_pkg::VAL_W-1:0] item_value;
        logic                             last;
    } list_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // request side, all driven from time zero
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [ils_pkg::FUNC_W-1:0]       s_func = ils_pkg::FUNC_INSERT;
    logic [ils_pkg::POS_W-1:0]        s_position = '0;
    logic signed [ils_pkg::VAL_W-1:0] s_value = '0;

    // result side
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [ils_pkg::STATUS_W-1:0]     m_status;
    logic [ils_pkg::CNT_W-1:0]        m_count;
    logic                             m_has_value;
    logic signed [ils_pkg::VAL_W-1:0] m_item_value;
    logic                             m_last;

    // shadow of the list contents and the queue of result words still owed
    logic signed [ils_pkg::VAL_W-1:0] shadow_list [ils_pkg::STORE_DEPTH];
    int                               shadow_count = 0;
    list_word_t                       expected_words [$];

    // idle percentages for the sender and the receiver, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // bookkeeping for the summary
    int error_count = 0;
    int words_checked = 0;
    int n_insert = 0;
    int n_remove = 0;
    int n_dump = 0;
    int n_ignored = 0;
    int n_rejected = 0;
    int peak_count = 0;
    int cycle_count = 0;

    indexed_list_store_top uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_position   (s_position),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_has_value  (m_has_value),
        .m_item_value (m_item_value),
        .m_last       (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d result words still owed",
                     $time, cycle_count, expected_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // queue one owed result word; count is the occupancy after the request
    function automatic void push_word(ils_pkg::status_t st, logic has,
                                      logic signed [ils_pkg::VAL_W-1:0] v, logic lst);
        list_word_t w;
        w.status = st;
        w.count = shadow_count[ils_pkg::CNT_W-1:0];
        w.has_value = has;
        w.item_value = v;
        w.last = lst;
        expected_words.push_back(w);
    endfunction

    // apply one accepted request word to the shadow list and owe its results
    function automatic void predict_list_op(logic [ils_pkg::FUNC_W-1:0] func,
                                            logic [ils_pkg::POS_W-1:0] pos,
                                            logic signed [ils_pkg::VAL_W-1:0] val);
        ils_pkg::status_t st;
        int i;
        st = ils_pkg::ST_OK;
        case (func)
            ils_pkg::FUNC_INSERT: begin
                n_insert++;
                // range check wins over the full check
                if (pos > shadow_count) begin
                    st = ils_pkg::ST_RANGE;
                end else if (shadow_count >= ils_pkg::USABLE_CAP) begin
                    st = ils_pkg::ST_FULL;
                end else begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = val;
                    shadow_count++;
                    if (shadow_count > peak_count)
                        peak_count = shadow_count;
                end
                if (st != ils_pkg::ST_OK)
                    n_rejected++;
                push_word(st, 1'b0, '0, 1'b1);
            end
            ils_pkg::FUNC_REMOVE: begin
                n_remove++;
                // empty wins over range
                if (shadow_count == 0) begin
                    st = ils_pkg::ST_EMPTY;
                end else if (pos >= shadow_count) begin
                    st = ils_pkg::ST_RANGE;
                end else begin
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                end
                if (st != ils_pkg::ST_OK)
                    n_rejected++;
                push_word(st, 1'b0, '0, 1'b1);
            end
            ils_pkg::FUNC_DUMP: begin
                n_dump++;
                if (shadow_count == 0) begin
                    push_word(ils_pkg::ST_EMPTY, 1'b0, '0, 1'b1);
                end else begin
                    for (i = 0; i < shadow_count; i++)
                        push_word(ils_pkg::ST_OK, 1'b1, shadow_list[i], i + 1 == shadow_count);
                end
            end
            default: begin
                // unused code: no state change, no result word
                n_ignored++;
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [ils_pkg::VAL_W-1:0] want,
                                        logic [ils_pkg::VAL_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // result checker: every accepted word against the oldest owed word
    always @(posedge aclk) begin : check_results
        list_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word, status %0d count %0d value 0x%h",
                         $time, m_status, m_count, m_item_value);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                check_field("status", want.status, m_status);
                check_field("count", want.count, m_count);
                check_field("has_value", want.has_value, m_has_value);
                check_field("item_value", want.item_value, m_item_value);
                check_field("last", want.last, m_last);
            end
        end
    end

    // receiver stalls, redrawn every cycle at the falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // mostly random words, with the extremes showing up often
    function automatic logic signed [ils_pkg::VAL_W-1:0] random_value();
        case ($urandom_range(19))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // send one request word; valid stays high across back-to-back words
    task automatic send_request(logic [ils_pkg::FUNC_W-1:0] func, int pos,
                                logic signed [ils_pkg::VAL_W-1:0] val);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_position <= pos[ils_pkg::POS_W-1:0];
        s_value <= val;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_list_op(func, pos[ils_pkg::POS_W-1:0], val);
    endtask

    // hold off the sender until every owed word has come back
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge aclk);
    endtask

    // edge requests on an empty, small and then emptied list
    task automatic test_edge_requests();
        send_request(ils_pkg::FUNC_DUMP, 0, '0);             // dump of empty list
        send_request(ils_pkg::FUNC_REMOVE, 0, '0);           // remove from empty list
        send_request(ils_pkg::FUNC_REMOVE, 63, '0);          // empty wins over range
        send_request(ils_pkg::FUNC_INSERT, 1, 32'sd7);       // insert past the end
        send_request(FUNC_UNUSED, 5, 32'sd9);                // ignored code
        send_request(ils_pkg::FUNC_INSERT, 0, VAL_MIN);
        send_request(ils_pkg::FUNC_INSERT, 1, VAL_MAX);      // append at the tail
        send_request(ils_pkg::FUNC_INSERT, 0, '1);           // new head
        send_request(ils_pkg::FUNC_INSERT, 1, '0);           // middle
        send_request(ils_pkg::FUNC_INSERT, 63, 32'sd1);      // largest position, out of range
        send_request(ils_pkg::FUNC_INSERT, 5, 32'sd1);       // one past count
        send_request(ils_pkg::FUNC_INSERT, 4, 32'sh5555_5555);
        send_request(ils_pkg::FUNC_DUMP, 0, '0);
        // sender pause: nothing goes in until the dump has drained
        wait_for_results();
        send_request(ils_pkg::FUNC_REMOVE, 5, '0);           // position equal to count
        send_request(ils_pkg::FUNC_REMOVE, 63, '0);
        send_request(ils_pkg::FUNC_REMOVE, 4, '0);           // tail
        send_request(ils_pkg::FUNC_REMOVE, 0, '0);           // head
        send_request(ils_pkg::FUNC_REMOVE, 1, '0);           // middle
        send_request(ils_pkg::FUNC_DUMP, 0, '0);
        send_request(ils_pkg::FUNC_REMOVE, 0, '0);
        send_request(ils_pkg::FUNC_REMOVE, 0, '0);           // the only entry, list empties
        send_request(ils_pkg::FUNC_DUMP, 0, '0);             // must report empty
        send_request(ils_pkg::FUNC_INSERT, 0, 32'shaaaa_aaaa);
        send_request(ils_pkg::FUNC_DUMP, 0, '0);
    endtask

    // fill to capacity, poke the full-store cases, then drain about half
    task automatic test_full_store();
        while (shadow_count < ils_pkg::USABLE_CAP)
            send_request(ils_pkg::FUNC_INSERT, $urandom_range(shadow_count), random_value());
        send_request(ils_pkg::FUNC_INSERT, shadow_count, random_value());  // full at the tail
        send_request(ils_pkg::FUNC_INSERT, 0, random_value());             // full at the head
        send_request(ils_pkg::FUNC_INSERT, 63, random_value());            // range before full
        send_request(ils_pkg::FUNC_REMOVE, 63, '0);
        send_request(ils_pkg::FUNC_DUMP, 0, '0);                           // longest dump
        while (shadow_count > ils_pkg::USABLE_CAP / 2) begin
            send_request(ils_pkg::FUNC_REMOVE, $urandom_range(shadow_count - 1),
                         random_value());
            if (shadow_count % 8 == 0)
                send_request(ils_pkg::FUNC_DUMP, 0, '0);
        end
    endtask

    // random mix, mostly well-formed positions, some wild ones and unused codes
    task automatic test_random_mix(int n_items);
        int done;
        int pick;
        int pos;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                pos = ($urandom_range(9) == 0) ? $urandom_range(63)
                                               : $urandom_range(shadow_count);
                send_request(ils_pkg::FUNC_INSERT, pos, random_value());
                done++;
            end else if (pick < 80) begin
                if (shadow_count == 0 || $urandom_range(9) == 0)
                    pos = $urandom_range(63);
                else
                    pos = $urandom_range(shadow_count - 1);
                send_request(ils_pkg::FUNC_REMOVE, pos, random_value());
                done++;
            end else if (pick < 96) begin
                send_request(ils_pkg::FUNC_DUMP, $urandom_range(63), random_value());
                done++;
            end else begin
                send_request(FUNC_UNUSED, $urandom_range(63), random_value());
            end
        end
    endtask

    initial begin
        // reset held from time zero, released at a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // phase one: light sender gaps, heavy receiver stalls
        send_idle_pct = 17;
        recv_stall_pct = 57;
        test_edge_requests();
        test_random_mix(45);
        wait_for_results();

        // phase two: the other way round
        send_idle_pct = 57;
        recv_stall_pct = 17;
        test_full_store();
        test_random_mix(35);
        wait_for_results();

        // phase three: full rate on both sides
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_mix(45);
        test_full_store();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (expected_words.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, expected_words.size());
            error_count++;
        end
        $display("run covered %0d inserts, %0d removes, %0d dumps, %0d ignored codes,",
                 n_insert, n_remove, n_dump, n_ignored);
        $display("%0d rejected, %0d result words checked, list peaked at %0d of %0d entries",
                 n_rejected, words_checked, peak_count, ils_pkg::USABLE_CAP);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
